// File: hdl/msdt_pkg.sv
// ----------------------------------------------------------------------------
// msdt_pkg
// Types and constants shared by the deadline timer controller and datapath.
// ----------------------------------------------------------------------------
package msdt_pkg;

  localparam int unsigned DISABLED_SECONDS = 3600;
  localparam logic [31:0] TPS_RESET = 32'd10000000;

  localparam logic [1:0] RK_ACK     = 2'd0;
  localparam logic [1:0] RK_FIRED   = 2'd1;
  localparam logic [1:0] RK_COMPARE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEG      = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] cur_tick;
    logic [31:0] delay_sec;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] fired_handle;
    logic [63:0] compare_tick;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic div_start; // start now/tps division
    logic scan_clr;  // reset scan pointer and min tracking
    logic scan_step; // examine one slot
    logic fire;      // free current slot and build fired beat
    logic write_add; // fill free slot
    logic mul_start; // start compare multiply
    logic out_ack;   // build add acknowledge beat
    logic out_cmp;   // build compare beat
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kind;
    logic neg;
    logic div_done;
    logic scan_end;
    logic slot_due;  // current slot valid and due (expire scan)
    logic have_free;
    logic mul_done;
  } dp_sts_t;

endpackage

// File: hdl/msdt_datapath.sv
// ----------------------------------------------------------------------------
// msdt_datapath
// Slot store, serial divider, scan pointer and serial multiplier.
// ----------------------------------------------------------------------------
module msdt_datapath #(
  parameter int NUM_SLOTS   = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  msdt_pkg::in_item_t  item,
  input  msdt_pkg::dp_cmd_t   cmd,
  output msdt_pkg::dp_sts_t   sts,
  output msdt_pkg::out_item_t beat
);
  import msdt_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int HB = (HANDLE_BITS > 32) ? 32 : HANDLE_BITS;

  logic [31:0] tps_r;
  logic [NUM_SLOTS-1:0] valid_r;
  logic [63:0] expiry_r [NUM_SLOTS];
  logic [HB-1:0] handle_r [NUM_SLOTS];
  logic [63:0] cur_sec_r;
  in_item_t item_r;

  logic [31:0] etps;
  assign etps = (tps_r == 32'd0) ? 32'd1 : tps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tps_r <= TPS_RESET;
    else if (cfg_we) tps_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
  end

  // restoring divider, one quotient bit per cycle
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  dcnt_r;
  logic        dbusy_r;
  logic [32:0] rtry;
  always_comb begin
    rtry    = {rem_r[31:0], quo_r[63]};
    quo_nxt = {quo_r[62:0], 1'b0};
    rem_nxt = rtry;
    if (rtry >= {1'b0, etps}) begin
      rem_nxt = rtry - {1'b0, etps};
      quo_nxt[0] = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= '0;
      quo_r   <= item_r.cur_tick;
      rem_r   <= '0;
    end else if (dbusy_r) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + 7'd1;
      if (dcnt_r == 7'd63) dbusy_r <= 1'b0;
    end
  end
  logic div_done;
  assign div_done = dbusy_r && (dcnt_r == 7'd63);
  always_ff @(posedge clk) begin
    if (div_done) cur_sec_r <= quo_nxt;
  end

  // slot scan
  logic [CW-1:0] ptr_r;
  logic [IW-1:0] pidx;
  logic          have_min_r;
  logic [63:0]   min_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  assign pidx = ptr_r[IW-1:0];

  logic pvalid;
  logic [63:0] pexp;
  assign pvalid = (ptr_r < CW'(NUM_SLOTS)) && valid_r[pidx];
  assign pexp   = expiry_r[pidx];

  logic due;
  assign due = pvalid && (item_r.kind == KIND_EXPIRE) && (pexp <= cur_sec_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      have_min_r   <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      ptr_r        <= '0;
      have_min_r   <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      ptr_r <= ptr_r + CW'(1);
      if (pvalid && !due) begin
        if (!have_min_r || pexp < min_r) min_r <= pexp;
        have_min_r <= 1'b1;
      end
      if (!pvalid && !free_found_r && ptr_r < CW'(NUM_SLOTS)) begin
        free_found_r <= 1'b1;
        free_idx_r   <= pidx;
      end
    end
  end

  logic [63:0] add_exp;
  assign add_exp = cur_sec_r + {32'd0, item_r.delay_sec};

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.write_add) valid_r[free_idx_r] <= 1'b1;
    else if (cmd.fire) valid_r[pidx] <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.write_add) begin
      expiry_r[free_idx_r] <= add_exp;
      handle_r[free_idx_r] <= item_r.handle[HB-1:0];
    end
  end

  // shift-add multiplier for the compare tick, one bit per cycle
  logic [63:0] mcand_r, acc_r;
  logic [31:0] mplier_r;
  logic [5:0]  mcnt_r;
  logic        mbusy_r, mone_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r  <= '0;
    end else if (cmd.mul_start) begin
      mbusy_r  <= 1'b1;
      mcnt_r   <= '0;
      mplier_r <= etps;
      acc_r    <= item_r.cur_tick;
      mone_r   <= have_min_r && (min_r <= cur_sec_r);
      mcand_r  <= have_min_r ? (min_r - cur_sec_r) : 64'(DISABLED_SECONDS);
    end else if (mbusy_r) begin
      if (mplier_r[0] && !mone_r) acc_r <= acc_r + mcand_r;
      mcand_r  <= {mcand_r[62:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[31:1]};
      mcnt_r   <= mcnt_r + 6'd1;
      if (mcnt_r == 6'd31) mbusy_r <= 1'b0;
    end
  end

  // output beat register
  out_item_t beat_r, beat_nxt;
  always_comb begin
    beat_nxt = '0;
    if (cmd.out_ack) begin
      beat_nxt.result_kind = RK_ACK;
      if (item_r.delay_sec[31]) begin
        beat_nxt.status = ST_NEG;
        beat_nxt.last   = 1'b1;
      end else if (!free_found_r) begin
        beat_nxt.status = ST_NO_SLOT;
        beat_nxt.last   = 1'b1;
      end else begin
        beat_nxt.slot_index = 4'(free_idx_r);
      end
    end else if (cmd.fire) begin
      beat_nxt.result_kind  = RK_FIRED;
      beat_nxt.slot_index   = 4'(pidx);
      beat_nxt.fired_handle = 32'(handle_r[pidx]);
    end else if (cmd.out_cmp) begin
      beat_nxt.result_kind  = RK_COMPARE;
      beat_nxt.compare_tick = mone_r ? item_r.cur_tick + 64'd1 : acc_r;
      beat_nxt.last         = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_ack || cmd.fire || cmd.out_cmp) beat_r <= beat_nxt;
  end
  assign beat = beat_r;

  assign sts.kind      = item_r.kind;
  assign sts.neg       = item_r.delay_sec[31];
  assign sts.div_done  = div_done;
  assign sts.scan_end  = (ptr_r >= CW'(NUM_SLOTS));
  assign sts.slot_due  = due;
  assign sts.have_free = free_found_r;
  assign sts.mul_done  = mbusy_r && (mcnt_r == 6'd31);

endmodule

// File: hdl/msdt_ctrl.sv
// ----------------------------------------------------------------------------
// msdt_ctrl
// Sequencer for add and expire items and the output beat handshake.
// ----------------------------------------------------------------------------
module msdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  msdt_pkg::dp_sts_t sts,
  output msdt_pkg::dp_cmd_t cmd
);
  import msdt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIV    = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_ACK    = 10'b0000001000,
    S_WACK   = 10'b0000010000,
    S_WFIRE  = 10'b0000100000,
    S_MUL    = 10'b0001000000,
    S_CMP    = 10'b0010000000,
    S_WCMP   = 10'b0100000000,
    S_RESCAN = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic outfree;

  assign outfree   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // negative add skips everything; divider result unused
        if (sts.kind == KIND_ADD && sts.neg) begin
          state_nxt = S_ACK;
        end else begin
          cmd.div_start = 1'b1;
          cmd.scan_clr  = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.div_done) state_nxt = S_WFIRE;
      end
      S_WFIRE: begin
        // one slot per cycle; a due slot waits for the output register
        if (sts.scan_end) begin
          state_nxt = (sts.kind == KIND_ADD) ? S_ACK : S_MUL;
          if (sts.kind != KIND_ADD) cmd.mul_start = 1'b1;
        end else if (sts.slot_due) begin
          if (outfree) begin
            cmd.fire      = 1'b1;
            cmd.scan_step = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ACK: begin
        if (outfree) begin
          cmd.out_ack   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_WACK;
        end
      end
      S_WACK: begin
        if (sts.neg || !sts.have_free) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.write_add = 1'b1;
          state_nxt     = S_CMP;
        end
      end
      S_CMP: begin
        // rescan so the minimum includes the new slot
        cmd.scan_clr = 1'b1;
        state_nxt    = S_RESCAN;
      end
      S_RESCAN: begin
        if (sts.scan_end) begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MUL: begin
        if (sts.mul_done) state_nxt = S_WCMP;
      end
      S_WCMP: begin
        if (outfree) begin
          cmd.out_cmp   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/multi_slot_deadline_timer_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_deadline_timer_unit
// Deadline slot table with add and expire scans and compare tick output.
// ----------------------------------------------------------------------------
// One item at a time. A serial divider forms the current second, the slot
// table is walked one slot a cycle (twice for a successful add) unless a due
// slot waits for a stalled output, and a shift-add multiplier forms the
// compare tick. Fired beats ride on the scan cycles. Result beats leave
// through a single output register.
module multi_slot_deadline_timer_unit #(
  parameter int NUM_SLOTS   = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  msdt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output msdt_pkg::out_item_t out_data
);
  import msdt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  msdt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  msdt_datapath #(.NUM_SLOTS(NUM_SLOTS), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .item(in_data), .cmd, .sts,
    .beat(out_data)
  );

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last) |=> in_stall)
    else $error("input taken mid item");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled beat changed");
`endif

endmodule
